>>> rtl/vpps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vpps_pkg
// Shared types and constants of the vibration pattern sequencer.
// ----------------------------------------------------------------------------
package vpps_pkg;

    // request codes on the input beat
    typedef enum logic {
        REQ_TICK  = 1'b0,
        REQ_WRITE = 1'b1
    } req_t;

    // payload field widths
    localparam int IDX_W  = 6;
    localparam int VAL_W  = 8;
    localparam int SLOT_W = 6;

    // fixed table layout
    localparam int BYTE_STRENGTH = 0;
    localparam int BYTE_PAIRS    = 1;
    localparam int SLOT_FIRST    = 2;

endpackage : vpps_pkg
`default_nettype wire

>>> rtl/vibration_pattern_pwm_sequencer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vibration_pattern_pwm_sequencer_core
// Motor pin sequencer driven from a pattern table: tick beats give one pin
// level and slot position, write beats store one table byte.
// ----------------------------------------------------------------------------
//   channel | handshake                   | payload
//   --------+-----------------------------+------------------------------------
//   in      | in_valid / in_stall         | req_type, param_index, param_value
//   out     | out_valid / out_stall       | drive, pattern_slot
//
// One beat is accepted per cycle unless in_stall is high; a tick result
// sits in the output register in the cycle after acceptance. A slot reload
// reads the table with its tick; the count goes to a tick right behind it.
// Reset clears the state and the table valid bits at once, with no sweep.
// in_stall is high while a result waits in the output register under stall.
// ----------------------------------------------------------------------------
module vibration_pattern_pwm_sequencer_core
    import vpps_pkg::*;
#(
    parameter int TABLE_BYTES    = 64,
    parameter int PWM_STEPS      = 10,
    parameter int TICKS_PER_UNIT = 10
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              req_type,
    input  wire logic [IDX_W-1:0]  param_index,
    input  wire logic [VAL_W-1:0]  param_value,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   drive,
    output logic      [SLOT_W-1:0] pattern_slot
);

    localparam int AW = $clog2(TABLE_BYTES);

    logic accept, tick, wr_en;
    logic rd_en;
    logic [AW-1:0] rd_addr;
    logic [VAL_W-1:0] rd_data, strength_byte, pairs_byte;
    logic drive_w;
    logic [AW-1:0] slot_w;
    logic out_valid_reg;
    logic drive_reg;
    logic [SLOT_W-1:0] slot_reg;

    // input beat decode
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign tick     = accept && (req_type == REQ_TICK);
    assign wr_en    = accept && (req_type == REQ_WRITE);

    vpps_table #(
        .TABLE_BYTES (TABLE_BYTES),
        .AW          (AW)
    ) u_table (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (wr_en),
        .wr_index      (param_index),
        .wr_value      (param_value),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .strength_byte (strength_byte),
        .pairs_byte    (pairs_byte)
    );

    vpps_seq #(
        .TABLE_BYTES    (TABLE_BYTES),
        .PWM_STEPS      (PWM_STEPS),
        .TICKS_PER_UNIT (TICKS_PER_UNIT),
        .AW             (AW)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick          (tick),
        .strength_byte (strength_byte),
        .pairs_byte    (pairs_byte),
        .rd_data       (rd_data),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .drive         (drive_w),
        .slot          (slot_w)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (tick)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (tick)
        begin
            drive_reg <= drive_w;
            slot_reg  <= SLOT_W'(slot_w);
        end
    end

    assign out_valid    = out_valid_reg;
    assign drive        = drive_reg;
    assign pattern_slot = slot_reg;

endmodule : vibration_pattern_pwm_sequencer_core
`default_nettype wire

>>> rtl/vpps_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vpps_table
// Pattern table memory with per-entry valid bits and shadow copies of the
// strength and pair-count bytes.
// ----------------------------------------------------------------------------
module vpps_table
    import vpps_pkg::*;
#(
    parameter int TABLE_BYTES = 64,
    parameter int AW          = 6
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_index,
    input  wire logic [VAL_W-1:0] wr_value,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [VAL_W-1:0] rd_data,
    output logic      [VAL_W-1:0] strength_byte,
    output logic      [VAL_W-1:0] pairs_byte
);

    logic [VAL_W-1:0] mem [TABLE_BYTES];
    logic [TABLE_BYTES-1:0] valid_reg;
    logic [VAL_W-1:0] rd_data_reg;
    logic rd_valid_reg;
    logic [VAL_W-1:0] strength_reg;
    logic [VAL_W-1:0] pairs_reg;
    logic in_range;
    logic [AW-1:0] wr_addr;

    // writes past the table end are dropped
    assign in_range = int'(wr_index) < TABLE_BYTES;
    assign wr_addr  = AW'(wr_index);

    // storage array, no reset
    always_ff @(posedge clk)
    begin
        if (wr_en && in_range)
        begin
            mem[wr_addr] <= wr_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // valid bits and shadow bytes, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            strength_reg <= '0;
            pairs_reg    <= '0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
            if (wr_en && in_range)
            begin
                valid_reg[wr_addr] <= 1'b1;
                if (wr_addr == AW'(BYTE_STRENGTH))
                begin
                    strength_reg <= wr_value;
                end
                if (wr_addr == AW'(BYTE_PAIRS))
                begin
                    pairs_reg <= wr_value;
                end
            end
        end
    end

    // never written entries read as zero
    assign rd_data       = rd_valid_reg ? rd_data_reg : '0;
    assign strength_byte = strength_reg;
    assign pairs_byte    = pairs_reg;

endmodule : vpps_table
`default_nettype wire

>>> rtl/vpps_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vpps_seq
// PWM phase, strength and slot countdown; issues the table read for a slot
// reload and forwards the reloaded count to a following tick.
// ----------------------------------------------------------------------------
module vpps_seq
    import vpps_pkg::*;
#(
    parameter int TABLE_BYTES    = 64,
    parameter int PWM_STEPS      = 10,
    parameter int TICKS_PER_UNIT = 10,
    parameter int AW             = 6
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             tick,
    input  wire logic [VAL_W-1:0] strength_byte,
    input  wire logic [VAL_W-1:0] pairs_byte,
    input  wire logic [VAL_W-1:0] rd_data,
    output logic                  rd_en,
    output logic      [AW-1:0]    rd_addr,
    output logic                  drive,
    output logic      [AW-1:0]    slot
);

    localparam int MAX_PAIRS = (TABLE_BYTES - 2) / 2;
    localparam int PHW       = $clog2(PWM_STEPS);
    localparam int CD_W      = $clog2(255 * TICKS_PER_UNIT + 1) + 1;

    logic [PHW-1:0] phase_reg, phase_next;
    logic [PHW:0] phase_inc;
    logic [VAL_W-1:0] strength_reg, strength_next;
    logic signed [CD_W-1:0] cd_reg, cd_next, cd_cur, cd_dec, cd_load;
    logic [AW-1:0] pos_reg, pos_next, pos_tick;
    logic pend_reg, pend_next;
    logic reload;
    logic [VAL_W-1:0] pairs;
    logic [AW:0] pos_inc, limit;

    // reloaded count from the table read of the previous cycle
    assign cd_load = $signed(CD_W'(rd_data) * CD_W'(TICKS_PER_UNIT));
    assign cd_cur  = pend_reg ? cd_load : cd_reg;
    assign cd_dec  = cd_cur - CD_W'(1);

    // clamped pair count and wrap limit
    assign pairs   = (int'(pairs_byte) > MAX_PAIRS) ? VAL_W'(MAX_PAIRS) : pairs_byte;
    assign limit   = ((AW + 1)'(pairs) << 1) + (AW + 1)'(SLOT_FIRST);
    assign pos_inc = {1'b0, pos_reg} + (AW + 1)'(1);

    // pwm phase and pin level
    assign phase_inc = {1'b0, phase_reg} + (PHW + 1)'(1);
    assign phase_next = (phase_inc >= (PHW + 1)'(PWM_STEPS)) ? '0 : PHW'(phase_inc);
    assign drive = (strength_reg != '0) && (VAL_W'(phase_next) < strength_reg);

    // slot step for one tick
    always_comb
    begin
        pos_tick      = '0;
        reload        = 1'b0;
        strength_next = strength_reg;
        pos_next      = pos_reg;
        cd_next       = cd_reg;
        pend_next     = 1'b0;
        if (pairs != '0)
        begin
            if ((cd_cur == '0) && (pos_reg == '0))
            begin
                pos_tick = AW'(SLOT_FIRST);
                reload   = 1'b1;
            end
            else if (cd_dec[CD_W-1] || (cd_dec == '0))
            begin
                pos_tick = (pos_inc >= limit) ? AW'(SLOT_FIRST) : AW'(pos_inc);
                reload   = 1'b1;
            end
            else
            begin
                pos_tick = pos_reg;
            end
        end
        if (tick)
        begin
            pos_next  = pos_tick;
            pend_next = reload;
            if (pairs != '0)
            begin
                cd_next       = cd_dec;
                strength_next = pos_tick[0] ? '0 : strength_byte;
            end
            else
            begin
                cd_next       = '0;
                strength_next = strength_byte;
            end
        end
        else if (pend_reg)
        begin
            cd_next = cd_load;
        end
    end

    assign rd_en   = tick && reload;
    assign rd_addr = pos_tick;
    assign slot    = pos_tick;

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= '0;
            strength_reg <= '0;
            cd_reg       <= '0;
            pos_reg      <= '0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            if (tick)
            begin
                phase_reg <= phase_next;
            end
            strength_reg <= strength_next;
            cd_reg       <= cd_next;
            pos_reg      <= pos_next;
            pend_reg     <= pend_next;
        end
    end

endmodule : vpps_seq
`default_nettype wire
